### hdl/sstfw_pkg.sv
// Shared types, bus codes and digit helpers for the seven-segment frame writer.
`timescale 1ns / 1ps

package sstfw_pkg;

  localparam logic       OP_TIME    = 1'b0;
  localparam logic       OP_BRIGHT  = 1'b1;

  localparam logic [7:0] CMD_DATA   = 8'h40;
  localparam logic [7:0] CMD_ADDR   = 8'hC0;
  localparam logic [7:0] CMD_BRIGHT = 8'h87;
  localparam logic [7:0] COLON_BIT  = 8'h80;

  localparam int SEC_PER_MIN = 60;
  localparam int DIGIT_BASE  = 10;

  // floor(v / 60) == (v * RECIP60_WIDE) >> 21 for any 16-bit v
  localparam int RECIP60_WIDE   = 34953;
  localparam int RECIP60_SHIFT  = 21;
  // floor(q / 60) == (q * RECIP60_NARROW) >> 16 for q <= 1092
  localparam int RECIP60_NARROW = 1093;

  // byte position within a time frame
  typedef enum logic [2:0] {
    SLOT_DATA     = 3'd0,
    SLOT_ADDR     = 3'd1,
    SLOT_MIN_TENS = 3'd2,
    SLOT_MIN_ONES = 3'd3,
    SLOT_SEC_TENS = 3'd4,
    SLOT_SEC_ONES = 3'd5
  } slot_t;

  typedef struct packed {
    logic       op;
    logic [7:0] bright;
    logic [7:0] min_tens;
    logic [7:0] min_ones;
    logic [7:0] sec_tens;
    logic [7:0] sec_ones;
  } frame_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h3f;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5b;
      4'd3:    pat = 8'h4f;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6d;
      4'd6:    pat = 8'h7d;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7f;
      4'd9:    pat = 8'h6f;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  // tens digit of a value below 60
  function automatic logic [2:0] tens_of(input logic [5:0] val);
    logic [2:0] t;
    t = '0;
    for (int i = 1; i < 6; i++) begin
      if (val >= 6'(DIGIT_BASE * i)) t = 3'(i);
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] val, input logic [2:0] tens);
    logic [5:0] rem;
    rem = val - 6'(6'(tens) * 6'(DIGIT_BASE));
    return rem[3:0];
  endfunction

endpackage

### hdl/sstfw_digits.sv
// Elastic four-stage pipeline: command register, minute/second split, digit patterns.
`timescale 1ns / 1ps

module sstfw_digits import sstfw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_seconds_count,
  input  logic        in_show_colon,
  input  logic [3:0]  in_brightness_level,
  output logic        frm_valid,
  input  logic        frm_ready,
  output frame_t      frm
);

  logic        s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic        s1_free, s2_free, s3_free, s4_free;

  logic        s1_op_r, s1_colon_r;
  logic [15:0] s1_count_r;
  logic [3:0]  s1_level_r;

  logic        s2_op_r, s2_colon_r;
  logic [15:0] s2_count_r;
  logic [3:0]  s2_level_r;
  logic [10:0] s2_q1_r;

  logic        s3_op_r, s3_colon_r;
  logic [3:0]  s3_level_r;
  logic [5:0]  s3_sec_r;
  logic [10:0] s3_q1_r;
  logic [4:0]  s3_q2_r;

  frame_t      s4_frame_r;

  logic [31:0] q1_prod;
  logic [10:0] q1_nxt;
  logic [15:0] sec_diff;
  logic [5:0]  sec_nxt;
  logic [20:0] q2_prod;
  logic [4:0]  q2_nxt;
  logic [10:0] min_diff;
  logic [5:0]  min_val;
  logic [2:0]  sec_tens, min_tens;
  logic [3:0]  sec_ones, min_ones;
  frame_t      frame_nxt;

  assign s4_free  = !s4_valid_r || frm_ready;
  assign s3_free  = !s3_valid_r || s4_free;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;

  assign frm_valid = s4_valid_r;
  assign frm       = s4_frame_r;

  always_comb begin
    // stage 2: whole minutes
    q1_prod = 32'(s1_count_r) * 32'(RECIP60_WIDE);
    q1_nxt  = q1_prod[RECIP60_SHIFT +: 11];
    // stage 3: seconds within the minute, whole hours
    sec_diff = s2_count_r - 16'(16'(s2_q1_r) * 16'(SEC_PER_MIN));
    sec_nxt  = sec_diff[5:0];
    q2_prod  = 21'(s2_q1_r) * 21'(RECIP60_NARROW);
    q2_nxt   = q2_prod[20:16];
    // stage 4: minutes within the hour, digits and patterns
    min_diff = s3_q1_r - 11'(11'(s3_q2_r) * 11'(SEC_PER_MIN));
    min_val  = min_diff[5:0];
    sec_tens = tens_of(s3_sec_r);
    sec_ones = ones_of(s3_sec_r, sec_tens);
    min_tens = tens_of(min_val);
    min_ones = ones_of(min_val, min_tens);

    frame_nxt.op       = s3_op_r;
    frame_nxt.bright   = CMD_BRIGHT + 8'(s3_level_r);
    frame_nxt.min_tens = seg_pattern(4'(min_tens));
    frame_nxt.min_ones = seg_pattern(min_ones) | (s3_colon_r ? COLON_BIT : 8'h00);
    frame_nxt.sec_tens = seg_pattern(4'(sec_tens));
    frame_nxt.sec_ones = seg_pattern(sec_ones);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r <= in_valid;
      if (s2_free) s2_valid_r <= s1_valid_r;
      if (s3_free) s3_valid_r <= s2_valid_r;
      if (s4_free) s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_op_r    <= in_op;
      s1_count_r <= in_seconds_count;
      s1_colon_r <= in_show_colon;
      s1_level_r <= in_brightness_level;
    end
    if (s2_free && s1_valid_r) begin
      s2_op_r    <= s1_op_r;
      s2_count_r <= s1_count_r;
      s2_colon_r <= s1_colon_r;
      s2_level_r <= s1_level_r;
      s2_q1_r    <= q1_nxt;
    end
    if (s3_free && s2_valid_r) begin
      s3_op_r    <= s2_op_r;
      s3_colon_r <= s2_colon_r;
      s3_level_r <= s2_level_r;
      s3_sec_r   <= sec_nxt;
      s3_q1_r    <= s2_q1_r;
      s3_q2_r    <= q2_nxt;
    end
    if (s4_free && s3_valid_r) begin
      s4_frame_r <= frame_nxt;
    end
  end

endmodule

### hdl/sstfw_framer.sv
// Frame sequencer: walks one frame out byte by byte into the output register.
`timescale 1ns / 1ps

module sstfw_framer import sstfw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       frm_valid,
  output logic       frm_ready,
  input  frame_t     frm,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_bus_byte,
  output logic       out_start_before,
  output logic       out_stop_after,
  output logic       out_last
);

  logic       frame_valid_r;
  frame_t     frame_r;
  slot_t      slot_r, slot_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_start_r, out_stop_r, out_last_r;

  logic       out_free, emit, cur_last;
  logic [7:0] byte_nxt;
  logic       start_nxt, stop_nxt, last_nxt;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = frame_valid_r && out_free;
  assign cur_last  = (frame_r.op == OP_BRIGHT) || (slot_r == SLOT_SEC_ONES);
  assign frm_ready = !frame_valid_r || (emit && cur_last);
  assign slot_nxt  = slot_t'(slot_r + 3'd1);

  always_comb begin
    byte_nxt  = 8'h00;
    start_nxt = 1'b0;
    stop_nxt  = 1'b0;
    last_nxt  = 1'b0;
    if (frame_r.op == OP_BRIGHT) begin
      byte_nxt  = frame_r.bright;
      start_nxt = 1'b1;
      stop_nxt  = 1'b1;
      last_nxt  = 1'b1;
    end else begin
      case (slot_r)
        SLOT_DATA: begin
          byte_nxt  = CMD_DATA;
          start_nxt = 1'b1;
          stop_nxt  = 1'b1;
        end
        SLOT_ADDR: begin
          byte_nxt  = CMD_ADDR;
          start_nxt = 1'b1;
        end
        SLOT_MIN_TENS: byte_nxt = frame_r.min_tens;
        SLOT_MIN_ONES: byte_nxt = frame_r.min_ones;
        SLOT_SEC_TENS: byte_nxt = frame_r.sec_tens;
        SLOT_SEC_ONES: begin
          byte_nxt = frame_r.sec_ones;
          stop_nxt = 1'b1;
          last_nxt = 1'b1;
        end
        default: byte_nxt = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
      slot_r        <= SLOT_DATA;
      out_valid_r   <= 1'b0;
    end else begin
      if (frm_ready) begin
        frame_valid_r <= frm_valid;
        slot_r        <= SLOT_DATA;
      end else if (emit) begin
        slot_r <= slot_nxt;
      end
      if (out_free) out_valid_r <= frame_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_ready && frm_valid) frame_r <= frm;
    if (emit) begin
      out_byte_r  <= byte_nxt;
      out_start_r <= start_nxt;
      out_stop_r  <= stop_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bus_byte     = out_byte_r;
  assign out_start_before = out_start_r;
  assign out_stop_after   = out_stop_r;
  assign out_last         = out_last_r;

endmodule

### hdl/seven_segment_time_frame_writer.sv
// Top level of the seven-segment display frame writer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in_     | input     | in_valid/in_stall   | op, seconds_count, show_colon, brightness_level
//   out_    | output    | out_valid/out_stall | bus_byte, start_before, stop_after, last
//
// A time item yields six bytes; a brightness item yields one byte, so those run
// at one item per cycle while out_stall is low. The output register, sending one
// byte per cycle when not stalled, sets that rate. After acceptance into the command
// register an item passes three more pipeline stages, the frame register, then the output register.
// Reset (rst_n low, synchronous) empties the pipeline and the output register.
// A stalled output holds its byte; stalls back up stage by stage to in_stall.
`timescale 1ns / 1ps

module seven_segment_time_frame_writer import sstfw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_seconds_count,
  input  logic        in_show_colon,
  input  logic [3:0]  in_brightness_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_bus_byte,
  output logic        out_start_before,
  output logic        out_stop_after,
  output logic        out_last
);

  logic   frm_valid;
  logic   frm_ready;
  frame_t frm;

  sstfw_digits u_digits (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_seconds_count    (in_seconds_count),
    .in_show_colon       (in_show_colon),
    .in_brightness_level (in_brightness_level),
    .frm_valid           (frm_valid),
    .frm_ready           (frm_ready),
    .frm                 (frm)
  );

  sstfw_framer u_framer (
    .clk              (clk),
    .rst_n            (rst_n),
    .frm_valid        (frm_valid),
    .frm_ready        (frm_ready),
    .frm              (frm),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bus_byte     (out_bus_byte),
    .out_start_before (out_start_before),
    .out_stop_after   (out_stop_after),
    .out_last         (out_last)
  );

endmodule

### hdl/sstfw_checker.sv
// Port-level checks for the frame writer, bound to the top level.
`timescale 1ns / 1ps

module sstfw_checker import sstfw_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_op,
  input logic [15:0] in_seconds_count,
  input logic        in_show_colon,
  input logic [3:0]  in_brightness_level,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_bus_byte,
  input logic        out_start_before,
  input logic        out_stop_after,
  input logic        out_last
);

  // synchronous reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // every frame ends on a stop
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_stop_after)
    else $error("last byte without stop");

  // a start with no stop only ever opens the address command
  a_addr_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_before && !out_stop_after |-> out_bus_byte == CMD_ADDR && !out_last)
    else $error("open start on a byte other than the address command");

  // within a frame the bytes follow with no gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a frame");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bus_byte) && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind seven_segment_time_frame_writer sstfw_checker u_sstfw_checker (.*);
